// ===== rtl/dhcpopt_pkg.sv =====
// Shared types and constants for the DHCP request option parser.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package dhcpopt_pkg;

  // Stream and hostname limits
  localparam int MAX_STREAM_BYTES = 1024;
  localparam int HOSTNAME_MAX     = 32;
  localparam int NAME_DEPTH       = 32;
  localparam int NAME_CAP         = (HOSTNAME_MAX < NAME_DEPTH) ? HOSTNAME_MAX : NAME_DEPTH;
  localparam int NAME_AW          = $clog2(NAME_DEPTH);
  localparam int NAME_LEN_W       = 6;

  // Consumed-byte counter and the wider sum used before saturation
  localparam int CNT_W   = $clog2(MAX_STREAM_BYTES + 1);
  localparam int SUM_W   = CNT_W + 9;
  localparam int COUNT_W = 11;

  // Parameter request map geometry
  localparam int MAP_WORDS  = 4;
  localparam int MAP_AW     = 2;
  localparam int MAP_WIDTH  = 64;
  localparam int MAP_BIT_W  = 6;

  // Result sequence layout: summary, map words, hostname bytes
  localparam int SEQ_W          = 6;
  localparam int FIRST_NAME_SEQ = 1 + MAP_WORDS;

  // Option tags
  localparam logic [7:0] END_TAG      = 8'hff;
  localparam logic [7:0] TAG_HOSTNAME = 8'd12;
  localparam logic [7:0] TAG_REQ_ADDR = 8'd50;
  localparam logic [7:0] TAG_MSG_TYPE = 8'd53;
  localparam logic [7:0] TAG_SERVER   = 8'd54;
  localparam logic [7:0] TAG_PARAMS   = 8'd55;

  // Result kinds
  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_MAP     = 2'd1;
  localparam logic [1:0] KIND_NAME    = 2'd2;

  // Read-modify-write request into the parameter map
  typedef struct packed {
    logic                 valid;
    logic [MAP_AW-1:0]    word;
    logic [MAP_BIT_W-1:0] bitpos;
  } map_upd_t;

  // Hostname store write
  typedef struct packed {
    logic               en;
    logic [NAME_AW-1:0] addr;
    logic [7:0]         data;
  } name_wr_t;

  // Scalar results of the parse, taken for the summary
  typedef struct packed {
    logic                  status;
    logic [COUNT_W-1:0]    consumed;
    logic [7:0]            msg_type;
    logic [31:0]           server;
    logic [31:0]           request;
    logic [NAME_LEN_W-1:0] name_len;
  } summary_t;

  // Read requests from the result sequencer into both memories
  typedef struct packed {
    logic               map_en;
    logic [MAP_AW-1:0]  map_addr;
    logic               name_en;
    logic [NAME_AW-1:0] name_addr;
  } rd_req_t;

endpackage

// ===== rtl/dhcpopt_parse.sv =====
// Option TLV parser: tag/length/content state and the fixed scalar fields.
// Depends on dhcpopt_pkg; drives the map and hostname memories.
`timescale 1ns / 1ps

module dhcpopt_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             opt_byte,
  input  logic                   clear,
  output dhcpopt_pkg::map_upd_t  map_upd,
  output dhcpopt_pkg::name_wr_t  name_wr,
  output dhcpopt_pkg::summary_t  summary
);
  import dhcpopt_pkg::*;

  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [1:0]            phase, phase_next;
  logic [7:0]            tag, tag_next;
  logic [7:0]            left, left_next;
  logic [7:0]            pos, pos_next;
  logic [CNT_W-1:0]      consumed, consumed_next;
  logic                  end_seen, end_seen_next;
  logic [7:0]            type_reg, type_next;
  logic [31:0]           server_reg, server_next;
  logic [31:0]           request_reg, request_next;
  logic [NAME_LEN_W-1:0] name_len, name_len_next;
  logic                  done;
  logic [8:0]            done_len;
  logic [SUM_W-1:0]      sum;
  logic [1:0]            lane;

  // Decode one byte against the current record state
  always_comb begin
    phase_next    = phase;
    tag_next      = tag;
    left_next     = left;
    pos_next      = pos;
    consumed_next = consumed;
    end_seen_next = end_seen;
    type_next     = type_reg;
    server_next   = server_reg;
    request_next  = request_reg;
    name_len_next = name_len;
    map_upd       = '0;
    name_wr       = '0;
    name_wr.data  = opt_byte;
    done          = 1'b0;
    done_len      = 9'd0;
    lane          = 2'd3 - pos[1:0];
    sum           = '0;
    if (accept && !end_seen) begin
      case (phase)
        PH_TAG: begin
          if (opt_byte == END_TAG) begin
            end_seen_next = 1'b1;
          end else begin
            tag_next   = opt_byte;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          left_next = opt_byte;
          pos_next  = 8'd0;
          if (tag == TAG_HOSTNAME) begin
            name_len_next = '0;
          end
          if (opt_byte == 8'd0) begin
            done = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          case (tag)
            TAG_MSG_TYPE: begin
              if (pos == 8'd0) type_next = opt_byte;
            end
            TAG_SERVER: begin
              if (pos < 8'd4) server_next[{lane, 3'b000} +: 8] = opt_byte;
            end
            TAG_REQ_ADDR: begin
              if (pos < 8'd4) request_next[{lane, 3'b000} +: 8] = opt_byte;
            end
            TAG_PARAMS: begin
              map_upd.valid  = 1'b1;
              map_upd.word   = opt_byte[7:6];
              map_upd.bitpos = opt_byte[MAP_BIT_W-1:0];
            end
            TAG_HOSTNAME: begin
              if (pos < 8'(NAME_CAP)) begin
                name_wr.en    = 1'b1;
                name_wr.addr  = pos[NAME_AW-1:0];
                name_len_next = NAME_LEN_W'(pos) + NAME_LEN_W'(1);
              end
            end
            default: begin
            end
          endcase
          pos_next  = pos + 8'd1;
          left_next = left - 8'd1;
          if (left == 8'd1) begin
            done     = 1'b1;
            done_len = {1'b0, pos} + 9'd1;
          end
        end
        default: phase_next = PH_TAG;
      endcase
      // Close the record and add its size, saturating
      if (done) begin
        sum = SUM_W'(consumed) + SUM_W'(done_len) + SUM_W'(2);
        consumed_next = (sum > SUM_W'(MAX_STREAM_BYTES)) ? CNT_W'(MAX_STREAM_BYTES)
                                                         : CNT_W'(sum);
        phase_next = PH_TAG;
      end
    end
  end

  // Hold the record state; drop everything at the end of the result burst
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase       <= PH_TAG;
      tag         <= '0;
      left        <= '0;
      pos         <= '0;
      consumed    <= '0;
      end_seen    <= 1'b0;
      type_reg    <= '0;
      server_reg  <= '0;
      request_reg <= '0;
      name_len    <= '0;
    end else begin
      phase       <= phase_next;
      tag         <= tag_next;
      left        <= left_next;
      pos         <= pos_next;
      consumed    <= consumed_next;
      end_seen    <= end_seen_next;
      type_reg    <= type_next;
      server_reg  <= server_next;
      request_reg <= request_next;
      name_len    <= name_len_next;
    end
  end

  assign summary.status   = !end_seen && (phase != PH_TAG);
  assign summary.consumed = COUNT_W'(consumed);
  assign summary.msg_type = type_reg;
  assign summary.server   = server_reg;
  assign summary.request  = request_reg;
  assign summary.name_len = name_len;

  // Once the end tag is seen the parser stays between records
  a_end_in_tag: assert property (@(posedge clk) disable iff (rst)
    end_seen |-> phase == PH_TAG)
    else $error("end tag seen while inside a record");

  a_name_cap: assert property (@(posedge clk) disable iff (rst)
    name_len <= NAME_LEN_W'(NAME_CAP))
    else $error("hostname length beyond cap");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> left != 8'd0)
    else $error("record body with no content left");

endmodule

// ===== rtl/dhcpopt_map.sv =====
// Parameter request map: 4 x 64 memory with read-modify-write and forwarding.
// Depends on dhcpopt_pkg; valid bits make unwritten words read as zero.
`timescale 1ns / 1ps

module dhcpopt_map (
  input  logic                               clk,
  input  logic                               rst,
  input  dhcpopt_pkg::map_upd_t              upd,
  input  logic                               emit_rd,
  input  logic [dhcpopt_pkg::MAP_AW-1:0]     emit_addr,
  input  logic                               clear,
  output logic [dhcpopt_pkg::MAP_WIDTH-1:0]  rd_word
);
  import dhcpopt_pkg::*;

  logic [MAP_WIDTH-1:0] mem [MAP_WORDS];
  logic [MAP_WIDTH-1:0] rd_data;
  logic [MAP_AW-1:0]    rd_addr, rd_addr_q;
  logic                 rd_en;
  logic [MAP_WORDS-1:0] valid_q;
  logic                 s2_valid;
  logic [MAP_BIT_W-1:0] s2_bit;
  logic                 wr_en;
  logic [MAP_WIDTH-1:0] wr_data;
  logic                 fwd_valid;
  logic [MAP_AW-1:0]    fwd_addr;
  logic [MAP_WIDTH-1:0] fwd_data;
  logic [MAP_WIDTH-1:0] cur;

  // Share the read port between the parser and the result sequencer
  assign rd_en   = upd.valid || emit_rd;
  assign rd_addr = upd.valid ? upd.word : emit_addr;

  // Memory: registered read, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      mem[rd_addr_q] <= wr_data;
    end
  end

  // Current word: take the last write if it hit the same entry
  assign cur = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data
             : (valid_q[rd_addr_q] ? rd_data : '0);
  assign rd_word = cur;

  // Modify stage: set one bit and write back
  assign wr_en   = s2_valid;
  assign wr_data = cur | (MAP_WIDTH'(1) << s2_bit);

  always_ff @(posedge clk) begin
    s2_bit   <= upd.bitpos;
    fwd_addr <= rd_addr_q;
    fwd_data <= wr_data;
    if (rst) begin
      s2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s2_valid  <= upd.valid;
      fwd_valid <= wr_en;
    end
  end

  // Valid bits: set on write, drop at the end of the burst
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[rd_addr_q] <= 1'b1;
    end
  end

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(upd.valid && emit_rd))
    else $error("parser and sequencer read the map together");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !clear)
    else $error("map write during clear");

  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(upd.valid))
    else $error("map write without a preceding read");

endmodule

// ===== rtl/dhcpopt_name.sv =====
// Hostname byte store: 32 x 8 memory, one write and one registered read port.
// Depends on dhcpopt_pkg.
`timescale 1ns / 1ps

module dhcpopt_name (
  input  logic                             clk,
  input  dhcpopt_pkg::name_wr_t            wr,
  input  logic                             rd_en,
  input  logic [dhcpopt_pkg::NAME_AW-1:0]  rd_addr,
  output logic [7:0]                       rd_data
);
  import dhcpopt_pkg::*;

  logic [7:0] mem [NAME_DEPTH];

  // Store bytes as they arrive; read on request
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/dhcpopt_emit.sv =====
// Result sequencer: summary, four map words, hostname bytes, into an output
// register. Depends on dhcpopt_pkg; reads both memories through rd_req.
`timescale 1ns / 1ps

module dhcpopt_emit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  dhcpopt_pkg::summary_t                 summary,
  input  logic [dhcpopt_pkg::MAP_WIDTH-1:0]     map_word,
  input  logic [7:0]                            name_byte,
  input  logic                                  out_stall,
  output dhcpopt_pkg::rd_req_t                  rd_req,
  output logic                                  busy,
  output logic                                  clear,
  output logic                                  out_valid,
  output logic [1:0]                            kind,
  output logic                                  status,
  output logic [dhcpopt_pkg::COUNT_W-1:0]       byte_count,
  output logic [7:0]                            msg_type,
  output logic [31:0]                           server_ip,
  output logic [31:0]                           requested_addr,
  output logic [dhcpopt_pkg::NAME_LEN_W-1:0]    hostname_len,
  output logic [4:0]                            word_index,
  output logic [dhcpopt_pkg::MAP_WIDTH-1:0]     payload,
  output logic                                  last_result
);
  import dhcpopt_pkg::*;

  logic [SEQ_W-1:0] issue_cnt;
  logic [SEQ_W-1:0] pend_seq;
  logic [SEQ_W-1:0] last_idx;
  logic [SEQ_W-1:0] map_seq;
  logic [SEQ_W-1:0] name_seq;
  logic             pend;
  logic             has_more;
  logic             issue;
  logic             load;
  logic             final_load;

  assign last_idx   = SEQ_W'(MAP_WORDS) + SEQ_W'(summary.name_len);
  assign has_more   = issue_cnt <= last_idx;
  assign load       = pend && (!out_valid || !out_stall);
  assign issue      = busy && has_more && (!pend || load);
  assign final_load = load && (pend_seq == last_idx);
  assign clear      = final_load;

  // Read requests for the item being issued
  assign map_seq           = issue_cnt - SEQ_W'(1);
  assign name_seq          = issue_cnt - SEQ_W'(FIRST_NAME_SEQ);
  assign rd_req.map_en     = issue && (issue_cnt != '0) && (issue_cnt < SEQ_W'(FIRST_NAME_SEQ));
  assign rd_req.map_addr   = map_seq[MAP_AW-1:0];
  assign rd_req.name_en    = issue && (issue_cnt >= SEQ_W'(FIRST_NAME_SEQ));
  assign rd_req.name_addr  = name_seq[NAME_AW-1:0];

  // Advance the burst: issue a read, then load its data into the output
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      issue_cnt <= '0;
    end else begin
      if (start) begin
        busy      <= 1'b1;
        issue_cnt <= '0;
      end else if (final_load) begin
        busy      <= 1'b0;
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + SEQ_W'(1);
      end
      if (issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_seq <= issue_cnt;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= 1'b0;
      byte_count     <= '0;
      msg_type       <= '0;
      server_ip      <= '0;
      requested_addr <= '0;
      hostname_len   <= '0;
      word_index     <= '0;
      payload        <= '0;
      last_result    <= final_load;
      if (pend_seq == '0) begin
        kind           <= KIND_SUMMARY;
        status         <= summary.status;
        byte_count     <= summary.consumed;
        msg_type       <= summary.msg_type;
        server_ip      <= summary.server;
        requested_addr <= summary.request;
        hostname_len   <= summary.name_len;
      end else if (pend_seq < SEQ_W'(FIRST_NAME_SEQ)) begin
        kind       <= KIND_MAP;
        word_index <= 5'(pend_seq - SEQ_W'(1));
        payload    <= map_word;
      end else begin
        kind       <= KIND_NAME;
        word_index <= 5'(pend_seq - SEQ_W'(FIRST_NAME_SEQ));
        payload    <= MAP_WIDTH'(name_byte);
      end
    end
  end

  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    issue |-> busy)
    else $error("read issued outside a burst");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend |-> busy)
    else $error("pending read outside a burst");

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    final_load |=> !busy && !pend)
    else $error("burst did not end after its last result");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("stream end accepted during a burst");

endmodule

// ===== rtl/dhcp_request_option_parser.sv =====
// DHCP request option parser, top level.
// Depends on dhcpopt_pkg, dhcpopt_parse, dhcpopt_map, dhcpopt_name, dhcpopt_emit.
`timescale 1ns / 1ps

// Option bytes are taken at one per clock while no result burst is running. A
// parameter-list byte (option 55) is a read-modify-write of the 4 x 64 map
// memory, with the previous write forwarded, so back-to-back list bytes still go
// one per clock. On the byte marked last_byte the block stalls its input while
// it sends 5 + hostname_len results (summary, four map words, hostname bytes),
// one per clock unless out_stall holds the output register, through the
// registered read ports of the map and hostname memories. The input opens again
// as soon as the last result is in the output register, and state is cleared at
// the same edge.

module dhcp_request_option_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          opt_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          kind,
  output logic                                status,
  output logic [dhcpopt_pkg::COUNT_W-1:0]     byte_count,
  output logic [7:0]                          msg_type,
  output logic [31:0]                         server_ip,
  output logic [31:0]                         requested_addr,
  output logic [dhcpopt_pkg::NAME_LEN_W-1:0]  hostname_len,
  output logic [4:0]                          word_index,
  output logic [dhcpopt_pkg::MAP_WIDTH-1:0]   payload,
  output logic                                last_result
);
  import dhcpopt_pkg::*;

  logic                 busy;
  logic                 accept;
  logic                 start;
  logic                 clear;
  map_upd_t             map_upd;
  name_wr_t             name_wr;
  summary_t             summary;
  rd_req_t              rd_req;
  logic [MAP_WIDTH-1:0] map_word;
  logic [7:0]           name_byte;

  // Hold input during the result burst
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign start    = accept && last_byte;

  dhcpopt_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opt_byte (opt_byte),
    .clear    (clear),
    .map_upd  (map_upd),
    .name_wr  (name_wr),
    .summary  (summary)
  );

  dhcpopt_map u_map (
    .clk       (clk),
    .rst       (rst),
    .upd       (map_upd),
    .emit_rd   (rd_req.map_en),
    .emit_addr (rd_req.map_addr),
    .clear     (clear),
    .rd_word   (map_word)
  );

  dhcpopt_name u_name (
    .clk     (clk),
    .wr      (name_wr),
    .rd_en   (rd_req.name_en),
    .rd_addr (rd_req.name_addr),
    .rd_data (name_byte)
  );

  dhcpopt_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .summary        (summary),
    .map_word       (map_word),
    .name_byte      (name_byte),
    .out_stall      (out_stall),
    .rd_req         (rd_req),
    .busy           (busy),
    .clear          (clear),
    .out_valid      (out_valid),
    .kind           (kind),
    .status         (status),
    .byte_count     (byte_count),
    .msg_type       (msg_type),
    .server_ip      (server_ip),
    .requested_addr (requested_addr),
    .hostname_len   (hostname_len),
    .word_index     (word_index),
    .payload        (payload),
    .last_result    (last_result)
  );

endmodule

// ===== tb/dhcp_request_option_parser_tb.sv =====
// Self-checking testbench for dhcp_request_option_parser.
// Depends on dhcpopt_pkg and the parser RTL; expected bursts come from an in-bench model.
`timescale 1ns / 1ps

module dhcp_request_option_parser_tb;
  import dhcpopt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 60;

  // Tag with no special handling in the block
  localparam logic [7:0] TAG_PAD    = 8'd0;

  typedef enum logic [1:0] {AT_TAG, AT_LEN, AT_BODY} parse_phase_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       is_last;
  } opt_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  status;
    logic [COUNT_W-1:0]    count;
    logic [7:0]            mtype;
    logic [31:0]           server;
    logic [31:0]           request;
    logic [NAME_LEN_W-1:0] name_len;
    logic [4:0]            index;
    logic [MAP_WIDTH-1:0]  data;
    logic                  last;
  } report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             opt_byte = 8'd0;
  logic                   last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             kind;
  logic                   status;
  logic [COUNT_W-1:0]     byte_count;
  logic [7:0]             msg_type;
  logic [31:0]            server_ip;
  logic [31:0]            requested_addr;
  logic [NAME_LEN_W-1:0]  hostname_len;
  logic [4:0]             word_index;
  logic [MAP_WIDTH-1:0]   payload;
  logic                   last_result;

  // Parse model state
  parse_phase_t           ph;
  logic [7:0]             cur_tag;
  int                     left;
  int                     pos;
  int                     consumed;
  logic                   end_seen;
  logic [7:0]             type_r;
  logic [31:0]            server_r;
  logic [31:0]            request_r;
  logic [MAP_WIDTH-1:0]   pmap [MAP_WORDS];
  logic [7:0]             names [NAME_DEPTH];
  int                     name_len;

  // Stimulus and expectation stores
  opt_item_t              pending_q [$];
  logic [7:0]             stream_buf [$];
  report_t                report_q [$];
  opt_item_t              next_item;
  report_t                seen;
  int                     queued_items = 0;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  int                     mismatches = 0;
  int                     idle_cycles = 0;
  logic                   in_taken = 1'b0;

  always #10 clk = ~clk;

  dhcp_request_option_parser uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opt_byte       (opt_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .status         (status),
    .byte_count     (byte_count),
    .msg_type       (msg_type),
    .server_ip      (server_ip),
    .requested_addr (requested_addr),
    .hostname_len   (hostname_len),
    .word_index     (word_index),
    .payload        (payload),
    .last_result    (last_result)
  );

  // Return the parse model to its idle state
  task automatic clear_parse();
    ph        = AT_TAG;
    cur_tag   = '0;
    left      = 0;
    pos       = 0;
    consumed  = 0;
    end_seen  = 1'b0;
    type_r    = '0;
    server_r  = '0;
    request_r = '0;
    foreach (pmap[i]) pmap[i] = '0;
    name_len  = 0;
  endtask

  // Add a finished option to the saturating byte count
  task automatic close_option(int len);
    consumed = (consumed + 2 + len > MAX_STREAM_BYTES) ? MAX_STREAM_BYTES : consumed + 2 + len;
    ph = AT_TAG;
  endtask

  task automatic take_content(logic [7:0] b);
    case (cur_tag)
      TAG_MSG_TYPE: if (pos == 0) type_r = b;
      TAG_SERVER:   if (pos < 4) server_r[(3 - pos) * 8 +: 8] = b;
      TAG_REQ_ADDR: if (pos < 4) request_r[(3 - pos) * 8 +: 8] = b;
      TAG_PARAMS:   pmap[b[7:6]][b[5:0]] = 1'b1;
      TAG_HOSTNAME: begin
        if (pos < NAME_CAP) begin
          names[pos] = b;
          name_len = pos + 1;
        end
      end
      default: ;
    endcase
  endtask

  // Queue the summary, the map words and the hostname bytes, then clear
  task automatic emit_report();
    report_t r;
    int      w;
    int      n;
    r          = '0;
    r.kind     = KIND_SUMMARY;
    r.status   = !end_seen && (ph != AT_TAG);
    r.count    = consumed[COUNT_W-1:0];
    r.mtype    = type_r;
    r.server   = server_r;
    r.request  = request_r;
    r.name_len = name_len[NAME_LEN_W-1:0];
    report_q.push_back(r);
    for (w = 0; w < MAP_WORDS; w++) begin
      r       = '0;
      r.kind  = KIND_MAP;
      r.index = w[4:0];
      r.data  = pmap[w];
      r.last  = (name_len == 0) && (w == MAP_WORDS - 1);
      report_q.push_back(r);
    end
    for (n = 0; n < name_len; n++) begin
      r       = '0;
      r.kind  = KIND_NAME;
      r.index = n[4:0];
      r.data  = {56'd0, names[n]};
      r.last  = (n == name_len - 1);
      report_q.push_back(r);
    end
    clear_parse();
  endtask

  // Advance the parse model by one accepted byte
  task automatic parse_byte(logic [7:0] b, logic fin);
    if (!end_seen) begin
      case (ph)
        AT_TAG: begin
          if (b == END_TAG) begin
            end_seen = 1'b1;
          end else begin
            cur_tag = b;
            ph = AT_LEN;
          end
        end
        AT_LEN: begin
          left = int'(b);
          pos  = 0;
          if (cur_tag == TAG_HOSTNAME) name_len = 0;
          if (b == 8'd0) close_option(0);
          else ph = AT_BODY;
        end
        default: begin
          take_content(b);
          pos  = (pos + 1) & 255;
          left = (left - 1) & 255;
          if (left == 0) close_option(pos);
        end
      endcase
    end
    if (fin) emit_report();
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Compare one output transfer against its expected report
  task automatic next_report_check(report_t want);
    check_field("kind", 64'(want.kind), 64'(seen.kind));
    check_field("status", 64'(want.status), 64'(seen.status));
    check_field("byte_count", 64'(want.count), 64'(seen.count));
    check_field("msg_type", 64'(want.mtype), 64'(seen.mtype));
    check_field("server_ip", 64'(want.server), 64'(seen.server));
    check_field("requested_addr", 64'(want.request), 64'(seen.request));
    check_field("hostname_len", 64'(want.name_len), 64'(seen.name_len));
    check_field("word_index", 64'(want.index), 64'(seen.index));
    check_field("payload", want.data, seen.data);
    check_field("last_result", 64'(want.last), 64'(seen.last));
  endtask

  // Stream building
  task automatic put(logic [7:0] b);
    stream_buf.push_back(b);
  endtask

  task automatic add_option(logic [7:0] tag, int len);
    put(tag);
    put(len[7:0]);
    repeat (len) put(8'($urandom_range(0, 255)));
  endtask

  // Mark the final byte and hand the stream to the driver
  task automatic send_stream();
    int i;
    for (i = 0; i < stream_buf.size(); i++) begin
      next_item.octet   = stream_buf[i];
      next_item.is_last = (i == stream_buf.size() - 1);
      pending_q.push_back(next_item);
    end
    queued_items += stream_buf.size();
    stream_buf.delete();
  endtask

  task automatic random_option();
    case ($urandom_range(0, 6))
      0: add_option(TAG_MSG_TYPE, ($urandom_range(0, 99) < 70) ? 1 : $urandom_range(0, 3));
      1: add_option(TAG_SERVER, ($urandom_range(0, 99) < 70) ? 4 : $urandom_range(0, 6));
      2: add_option(TAG_REQ_ADDR, ($urandom_range(0, 99) < 70) ? 4 : $urandom_range(0, 6));
      3: add_option(TAG_PARAMS, $urandom_range(0, 8));
      4: add_option(TAG_HOSTNAME,
                    ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(30, 40));
      5: add_option(TAG_PAD, $urandom_range(0, 2));
      default: add_option(8'($urandom_range(1, 254)), $urandom_range(0, 5));
    endcase
  endtask

  // Mostly well-formed streams, some noise, some cut short
  task automatic random_stream();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 5)) random_option();
      if ($urandom_range(0, 99) < 80) begin
        put(END_TAG);
        repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
      end
      if (roll >= 85 && stream_buf.size() > 1)
        repeat ($urandom_range(1, stream_buf.size() - 1)) void'(stream_buf.pop_back());
    end
    if (stream_buf.size() == 0) put(END_TAG);
    send_stream();
  endtask

  // Hold the sender until every queued byte is taken and every report has arrived
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: present the next byte, hold it while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_q.pop_front();
          in_valid  <= 1'b1;
          opt_byte  <= next_item.octet;
          last_byte <= next_item.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (in_valid && !in_stall) parse_byte(opt_byte, last_byte);
      if (out_valid && !out_stall) begin
        seen = '{kind, status, byte_count, msg_type, server_ip, requested_addr,
                 hostname_len, word_index, payload, last_result};
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result with none expected: kind %0d index %0d", kind, word_index);
        end else begin
          next_report_check(report_q.pop_front());
        end
      end
    end
    // Watchdog on cycles without any transfer
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_i;
    int start_count;
    clear_parse();
    foreach (names[i]) names[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // End tag alone
    put(END_TAG);
    send_stream();
    // Message type, short server id, parameter list and hostname, map codes at both extremes
    put(TAG_MSG_TYPE); put(8'd1); put(8'd3);
    put(TAG_SERVER); put(8'd2); put(8'haa); put(8'hbb);
    put(TAG_PARAMS); put(8'd2); put(8'd0); put(8'hff);
    put(TAG_HOSTNAME); put(8'd2); put(8'h68); put(8'h69);
    put(END_TAG);
    send_stream();
    // Pad handled as a record, then the stream ends inside an option
    put(TAG_PAD); put(8'd0);
    put(TAG_REQ_ADDR); put(8'd5); put(8'hff); put(8'h00);
    send_stream();
    // Stream ends between options with no end tag
    put(TAG_MSG_TYPE); put(8'd1); put(8'd7);
    send_stream();

    // Pause the sender until all reports are in
    wait_idle();

    for (phase_i = 0; phase_i < 4; phase_i++) begin
      case (phase_i)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      start_count = queued_items;
      while (queued_items - start_count < PHASE_ITEMS) random_stream();
      wait_idle();
    end

    if (mismatches == 0 && report_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
